>>> hw/rtl/md5_pkg.sv
// ---------------------------------------------------------------------------
// MD5 package
// Shared constants, round tables, controller states and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 61;
    localparam int unsigned ROUND_W = 6;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned DIGEST_WORDS = 4;

    localparam logic [1:0] LAST_WORD_IDX = 2'd3;
    localparam logic [5:0] BLOCK_END_POS = 6'd63;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE      = 8'h80;

    localparam logic [WORD_W-1:0] CHAIN_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [ROUND_W-1:0] r);
        logic [7:0] prod;
        prod = 8'd0;
        case (r[5:4])
            2'd0: prod = {4'b0, r[3:0]};
            2'd1: prod = {4'b0, r[3:0]} * 8'd5 + 8'd1;
            2'd2: prod = {4'b0, r[3:0]} * 8'd3 + 8'd5;
            2'd3: prod = {4'b0, r[3:0]} * 8'd7;
            default: prod = 8'd0;
        endcase
        return prod[3:0];
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } md5_state_t;

    typedef struct packed {
        logic       load_byte;
        logic       pad;
        logic       len_block;
        logic       start;
        logic       round;
        logic       fold;
        logic       init;
        logic [1:0] word_sel;
    } md5_cmd_t;

    typedef struct packed {
        logic block_end;
        logic pad_extra;
        logic round_last;
    } md5_status_t;

endpackage

>>> hw/rtl/md5_ctrl.sv
// ---------------------------------------------------------------------------
// MD5 controller
// Sequences byte loading, padding, compression and digest output.
// ---------------------------------------------------------------------------
module md5_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 has_byte,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           word_index,
    output logic                 last_word,
    output md5_pkg::md5_cmd_t    cmd,
    input  md5_pkg::md5_status_t status
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    logic       last_pending_reg, last_pending_next;
    logic       need_len_reg, need_len_next;
    logic       final_reg, final_next;
    logic [1:0] word_idx_reg, word_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            last_pending_reg <= 1'b0;
            need_len_reg     <= 1'b0;
            final_reg        <= 1'b0;
            word_idx_reg     <= 2'd0;
        end
        else
        begin
            state_reg        <= state_next;
            last_pending_reg <= last_pending_next;
            need_len_reg     <= need_len_next;
            final_reg        <= final_next;
            word_idx_reg     <= word_idx_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        last_pending_next = last_pending_reg;
        need_len_next     = need_len_reg;
        final_next        = final_reg;
        word_idx_next     = word_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && status.block_end)
                    begin
                        last_pending_next = end_of_message;
                        state_next        = ST_START;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (need_len_reg)
                begin
                    state_next = ST_LEN;
                end
                else if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (last_pending_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                last_pending_next = 1'b0;
                need_len_next     = status.pad_extra;
                final_next        = !status.pad_extra;
                state_next        = ST_START;
            end
            ST_LEN:
            begin
                need_len_next = 1'b0;
                final_next    = 1'b1;
                state_next    = ST_START;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    word_idx_next = word_idx_reg + 2'd1;
                    if (word_idx_reg == LAST_WORD_IDX)
                    begin
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.word_sel  = word_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_byte = in_valid && has_byte;
            end
            ST_START: cmd.start     = 1'b1;
            ST_ROUND: cmd.round     = 1'b1;
            ST_FOLD:  cmd.fold      = 1'b1;
            ST_PAD:   cmd.pad       = 1'b1;
            ST_LEN:   cmd.len_block = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.init  = out_ready && (word_idx_reg == LAST_WORD_IDX);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign word_index = word_idx_reg;
    assign last_word  = (word_idx_reg == LAST_WORD_IDX);

endmodule

>>> hw/rtl/md5_datapath.sv
// ---------------------------------------------------------------------------
// MD5 datapath
// Message block, byte count, working words, one round per cycle and the
// chaining words.
// ---------------------------------------------------------------------------
module md5_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        data_byte,
    input  md5_pkg::md5_cmd_t                 cmd,
    output md5_pkg::md5_status_t              status,
    output logic [md5_pkg::WORD_W-1:0]        digest_word
);
    import md5_pkg::*;

    logic [WORD_W-1:0]  blk_reg   [BLK_WORDS];
    logic [WORD_W-1:0]  chain_reg [DIGEST_WORDS];
    logic [WORD_W-1:0]  work_reg  [DIGEST_WORDS];
    logic [COUNT_W-1:0] count_reg;
    logic [ROUND_W-1:0] round_reg;

    logic [5:0]        pos;
    logic [3:0]        pos_word;
    logic [4:0]        pos_shift;
    logic [WORD_W-1:0] len_lo;
    logic [WORD_W-1:0] len_hi;

    logic [WORD_W-1:0] a, b, c, d;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] t;
    logic [63:0]       t_dbl;
    logic [WORD_W-1:0] t_rot;
    logic [4:0]        s;

    assign pos       = count_reg[5:0];
    assign pos_word  = pos[5:2];
    assign pos_shift = {pos[1:0], 3'b000};
    assign len_lo    = {count_reg[28:0], 3'b000};
    assign len_hi    = count_reg[60:29];

    assign status.block_end  = (pos == BLOCK_END_POS);
    assign status.pad_extra  = (pos >= LEN_FIELD_POS);
    assign status.round_last = (round_reg == 6'd63);

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];

    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = '0;
        endcase
    end

    assign s     = ROT_S[{round_reg[5:4], round_reg[1:0]}];
    assign t     = a + f + blk_reg[msg_index(round_reg)] + ROUND_K[round_reg];
    assign t_dbl = {t, t} << s;
    assign t_rot = t_dbl[63:32];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < BLK_WORDS; j++)
        begin
            if (((cmd.pad && !status.pad_extra) || cmd.len_block) && (j >= BLK_WORDS - 2))
            begin
                blk_reg[j] <= (j == BLK_WORDS - 2) ? len_lo : len_hi;
            end
            else if (cmd.len_block)
            begin
                blk_reg[j] <= '0;
            end
            else if (cmd.pad)
            begin
                if (pos_word == 4'(j))
                begin
                    if (pos[1:0] == 2'd0)
                    begin
                        blk_reg[j] <= {24'd0, PAD_BYTE};
                    end
                    else
                    begin
                        blk_reg[j][pos_shift +: 8] <= PAD_BYTE;
                    end
                end
                else if (4'(j) > pos_word)
                begin
                    blk_reg[j] <= '0;
                end
            end
            else if (cmd.load_byte && (pos_word == 4'(j)))
            begin
                if (pos[1:0] == 2'd0)
                begin
                    blk_reg[j] <= {24'd0, data_byte};
                end
                else
                begin
                    blk_reg[j][pos_shift +: 8] <= data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            work_reg[0] <= d;
            work_reg[1] <= b + t_rot;
            work_reg[2] <= b;
            work_reg[3] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= CHAIN_INIT[i];
            end
            count_reg <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_reg[i] <= CHAIN_INIT[i];
                end
                count_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    for (int i = 0; i < DIGEST_WORDS; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.load_byte)
                begin
                    count_reg <= count_reg + 61'd1;
                end
            end
            if (cmd.start)
            begin
                round_reg <= '0;
            end
            else if (cmd.round)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    assign digest_word = chain_reg[cmd.word_sel];

endmodule

>>> hw/rtl/md5_message_digest.sv
// ---------------------------------------------------------------------------
// MD5 message digest
// Byte-serial MD5 hash: packs message bytes, compresses each 64-byte block,
// pads on the last item and returns the digest as four 32-bit words.
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_ready  data_byte, has_byte, end_of_message
//   output   out_valid/out_ready  digest_word, word_index, last_word
//
// Bytes are accepted while the block is idle; each full block is then
// compressed (load of the working words, 64 rounds on the single round
// unit, chain fold) before the next byte is taken. The last item adds a
// padding step, one or two block compressions and four output words.
// Reset loads the initial chaining words and clears the byte count.
// The input is held off during compression and while digest words wait.
// ---------------------------------------------------------------------------
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .cmd            (cmd),
        .status         (status)
    );

    md5_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule
